### sv/tcrc_pkg.sv
`default_nettype none

package tcrc_pkg;

    // Operation codes carried in the func field of a command item.
    typedef enum logic [1:0] {
        FUNC_SAMPLE      = 2'd0,
        FUNC_MAP_WRITE   = 2'd1,
        FUNC_COUNT_READ  = 2'd2,
        FUNC_COUNT_CLEAR = 2'd3
    } func_t;

    // Sensor arrangement: three sensors of twelve channels each.
    localparam int SENSOR_COUNT = 3;
    localparam int SENSOR_WIDTH = 12;

    // Payload field widths.
    localparam int SENSOR_W    = SENSOR_COUNT * SENSOR_WIDTH;
    localparam int CHANNEL_W   = 6;
    localparam int KEY_INDEX_W = 8;
    localparam int KEY_MAP_W   = 34;
    localparam int COUNT_W     = 32;

    // Default sizes of the table, the key map and the counters.
    localparam int CHANNELS_DEF   = 36;
    localparam int KEYS_DEF       = 34;
    localparam int COUNT_BITS_DEF = 32;

endpackage

`default_nettype wire

### sv/tcrc_cmd_if.sv
`default_nettype none

interface tcrc_cmd_if;
    import tcrc_pkg::*;

    logic                   valid;
    logic                   ready;
    func_t                  func;
    logic [SENSOR_W-1:0]    sensor_bits;
    logic [CHANNEL_W-1:0]   channel;
    logic [KEY_INDEX_W-1:0] key_index;

    modport source (
        output valid,
        input  ready,
        output func,
        output sensor_bits,
        output channel,
        output key_index
    );

    modport sink (
        input  valid,
        output ready,
        input  func,
        input  sensor_bits,
        input  channel,
        input  key_index
    );

endinterface

`default_nettype wire

### sv/tcrc_rsp_if.sv
`default_nettype none

interface tcrc_rsp_if;
    import tcrc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KEY_MAP_W-1:0] touched_keys;
    logic [KEY_MAP_W-1:0] new_touches;
    logic [COUNT_W-1:0]   key_count;

    modport source (
        output valid,
        input  ready,
        output touched_keys,
        output new_touches,
        output key_count
    );

    modport sink (
        input  valid,
        output ready,
        input  touched_keys,
        input  new_touches,
        input  key_count
    );

endinterface

`default_nettype wire

### sv/touch_channel_remap_counter_top.sv
`default_nettype none

// An accepted command item is loaded into the command register, and from there into
// the result register once that register is free or being emptied.
// Throughput: one item per cycle unless rsp.ready stalls; the table decode and all
// counter increments are done in the single logic stage between the two registers.
// Reset: the channel table reads identity, the key map and all counters are zero.
module touch_channel_remap_counter_top #(
    parameter int CHANNELS   = tcrc_pkg::CHANNELS_DEF,
    parameter int KEYS       = tcrc_pkg::KEYS_DEF,
    parameter int COUNT_BITS = tcrc_pkg::COUNT_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    tcrc_cmd_if.sink   cmd,
    tcrc_rsp_if.source rsp
);
    import tcrc_pkg::*;

    localparam int CH_W = (CHANNELS > SENSOR_W) ? CHANNELS : SENSOR_W;
    localparam int KM_W = (KEYS > KEY_MAP_W) ? KEYS : KEY_MAP_W;
    localparam int CT_W = (COUNT_BITS > COUNT_W) ? COUNT_BITS : COUNT_W;

    // Command register stage.
    logic                   s1_valid_reg, s1_valid_next;
    func_t                  s1_func_reg;
    logic [SENSOR_W-1:0]    s1_sensor_reg;
    logic [CHANNEL_W-1:0]   s1_channel_reg;
    logic [KEY_INDEX_W-1:0] s1_key_reg;

    // Block state. The previous key map always equals the current one after a
    // sample, so a single register serves as both.
    logic [KEY_INDEX_W-1:0] map_reg     [CHANNELS];
    logic [KEY_INDEX_W-1:0] map_next    [CHANNELS];
    logic [COUNT_BITS-1:0]  counter_reg [KEYS];
    logic [COUNT_BITS-1:0]  counter_next[KEYS];
    logic [KEYS-1:0]        key_map_reg, key_map_next;

    // Result register stage.
    logic                 res_valid_reg, res_valid_next;
    logic [KEY_MAP_W-1:0] res_touched_reg, res_touched_next;
    logic [KEY_MAP_W-1:0] res_fresh_reg, res_fresh_next;
    logic [COUNT_W-1:0]   res_count_reg, res_count_next;

    logic                  cmd_fire;
    logic                  advance;
    logic                  s2_fire;
    logic [CH_W-1:0]       raw_wide;
    logic [CHANNELS-1:0]   raw_ch;
    logic [KEYS-1:0]       routed;
    logic [KEYS-1:0]       fresh;
    logic [COUNT_BITS-1:0] count_sel;
    logic [KM_W-1:0]       touched_wide;
    logic [KM_W-1:0]       fresh_wide;
    logic [CT_W-1:0]       count_wide;
    logic                  any_count;

    // Handshake: the command stage moves on whenever the result register is
    // free or being emptied.
    assign advance   = !res_valid_reg || rsp.ready;
    assign s2_fire   = s1_valid_reg && advance;
    assign cmd.ready = !s1_valid_reg || advance;
    assign cmd_fire  = cmd.valid && cmd.ready;

    assign rsp.valid        = res_valid_reg;
    assign rsp.touched_keys = res_touched_reg;
    assign rsp.new_touches  = res_fresh_reg;
    assign rsp.key_count    = res_count_reg;

    // Raw channel bits. Each sensor field is already exactly twelve bits wide,
    // so masking per sensor leaves the word unchanged.
    always_comb
    begin
        raw_wide = CH_W'(s1_sensor_reg);
        raw_ch   = raw_wide[CHANNELS-1:0];
    end

    // Route every set channel through its table entry; entries naming a key
    // beyond the map drop the touch.
    always_comb
    begin
        routed = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            for (int k = 0; k < KEYS; k++)
            begin
                if (raw_ch[c] && (map_reg[c] == KEY_INDEX_W'(k)))
                begin
                    routed[k] = 1'b1;
                end
            end
        end
        fresh = routed & ~key_map_reg;
    end

    // Counter read select; a key beyond the map matches nothing and reads zero.
    always_comb
    begin
        count_sel = '0;
        for (int k = 0; k < KEYS; k++)
        begin
            if (s1_key_reg == KEY_INDEX_W'(k))
            begin
                count_sel = counter_reg[k];
            end
        end
    end

    // Next state of the table, key map and counters for the item in flight.
    always_comb
    begin
        map_next     = map_reg;
        counter_next = counter_reg;
        key_map_next = key_map_reg;
        if (s2_fire)
        begin
            unique case (s1_func_reg)
                FUNC_SAMPLE:
                begin
                    key_map_next = routed;
                    for (int k = 0; k < KEYS; k++)
                    begin
                        if (fresh[k])
                        begin
                            counter_next[k] = counter_reg[k] + COUNT_BITS'(1);
                        end
                    end
                end
                FUNC_MAP_WRITE:
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (s1_channel_reg == CHANNEL_W'(c))
                        begin
                            map_next[c] = s1_key_reg;
                        end
                    end
                end
                FUNC_COUNT_READ:
                begin
                end
                FUNC_COUNT_CLEAR:
                begin
                    for (int k = 0; k < KEYS; k++)
                    begin
                        counter_next[k] = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result fields, resized to the port widths.
    always_comb
    begin
        touched_wide     = KM_W'(key_map_next);
        fresh_wide       = (s1_func_reg == FUNC_SAMPLE) ? KM_W'(fresh) : '0;
        count_wide       = (s1_func_reg == FUNC_COUNT_READ) ? CT_W'(count_sel) : '0;
        res_touched_next = touched_wide[KEY_MAP_W-1:0];
        res_fresh_next   = fresh_wide[KEY_MAP_W-1:0];
        res_count_next   = count_wide[COUNT_W-1:0];
    end

    // Valid flags of both stages.
    always_comb
    begin
        if (cmd_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s2_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            key_map_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                map_reg[c] <= KEY_INDEX_W'(c);
            end
            for (int k = 0; k < KEYS; k++)
            begin
                counter_reg[k] <= '0;
            end
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            key_map_reg   <= key_map_next;
            map_reg       <= map_next;
            counter_reg   <= counter_next;
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_func_reg    <= cmd.func;
            s1_sensor_reg  <= cmd.sensor_bits;
            s1_channel_reg <= cmd.channel;
            s1_key_reg     <= cmd.key_index;
        end
        if (s2_fire)
        begin
            res_touched_reg <= res_touched_next;
            res_fresh_reg   <= res_fresh_next;
            res_count_reg   <= res_count_next;
        end
    end

    // Any counter nonzero, for checking the clear operation.
    always_comb
    begin
        any_count = 1'b0;
        for (int k = 0; k < KEYS; k++)
        begin
            any_count = any_count | (|counter_reg[k]);
        end
    end

    // A newly touched key is always part of the reported key map.
    a_fresh_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((rsp.new_touches & ~rsp.touched_keys) == '0))
        else $error("new touch outside the key map");

    // A count and new touches never come from the same item.
    a_count_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.key_count != '0)) |-> (rsp.new_touches == '0))
        else $error("count reported together with new touches");

    // Clearing leaves every counter at zero.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && (s1_func_reg == FUNC_COUNT_CLEAR)) |=> !any_count)
        else $error("counter nonzero after clear");

    // Only a sample changes the key map.
    a_map_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_fire && (s1_func_reg != FUNC_SAMPLE)) |=> $stable(key_map_reg))
        else $error("key map changed by a non-sample item");

    // A result item only appears after a processed command item.
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s2_fire))
        else $error("result item without a command item");

endmodule

`default_nettype wire

### test/touch_channel_remap_counter_top_tb.sv
`default_nettype none

module touch_channel_remap_counter_top_tb;
    import tcrc_pkg::*;

    // One command item as it travels on the command channel.
    typedef struct packed {
        func_t                  func;
        logic [SENSOR_W-1:0]    sensor_bits;
        logic [CHANNEL_W-1:0]   channel;
        logic [KEY_INDEX_W-1:0] key_index;
    } touch_cmd_t;

    // One result item as it travels on the response channel.
    typedef struct packed {
        logic [KEY_MAP_W-1:0] touched_keys;
        logic [KEY_MAP_W-1:0] new_touches;
        logic [COUNT_W-1:0]   key_count;
    } touch_rsp_t;

    // A directed row; when has_answer is set the answer is written out by hand.
    typedef struct packed {
        touch_cmd_t cmd;
        logic       has_answer;
        touch_rsp_t answer;
    } directed_row_t;

    localparam logic [SENSOR_W-1:0]  ALL_CHANNELS = 36'hF_FFFF_FFFF;
    localparam logic [KEY_MAP_W-1:0] ALL_KEYS     = 34'h3_FFFF_FFFF;
    localparam touch_rsp_t           ZERO_RSP     = '0;
    localparam int                   DIRECTED_ROWS = 23;
    localparam int                   MAX_REPORTS   = 40;

    // Directed stimulus: reset values, extremes, remapping corner cases and clears.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{FUNC_COUNT_READ,  36'h0,           6'd0,  8'd0},   1'b1, ZERO_RSP},
        '{'{FUNC_COUNT_READ,  36'h0,           6'd0,  8'd255}, 1'b1, ZERO_RSP},
        '{'{FUNC_SAMPLE,      ALL_CHANNELS,    6'd0,  8'd0},   1'b1,
            '{ALL_KEYS, ALL_KEYS, 32'd0}},
        '{'{FUNC_SAMPLE,      ALL_CHANNELS,    6'd0,  8'd0},   1'b1,
            '{ALL_KEYS, 34'h0, 32'd0}},
        '{'{FUNC_COUNT_READ,  36'h0,           6'd0,  8'd33},  1'b1,
            '{ALL_KEYS, 34'h0, 32'd1}},
        '{'{FUNC_SAMPLE,      36'h0,           6'd0,  8'd0},   1'b1, ZERO_RSP},
        '{'{FUNC_MAP_WRITE,   36'h0,           6'd35, 8'd0},   1'b1, ZERO_RSP},
        '{'{FUNC_MAP_WRITE,   36'h0,           6'd63, 8'd5},   1'b1, ZERO_RSP},
        '{'{FUNC_MAP_WRITE,   36'h0,           6'd34, 8'd255}, 1'b1, ZERO_RSP},
        '{'{FUNC_MAP_WRITE,   36'h0,           6'd1,  8'd0},   1'b1, ZERO_RSP},
        '{'{FUNC_SAMPLE,      36'h8_0000_0000, 6'd0,  8'd0},   1'b1,
            '{34'h1, 34'h1, 32'd0}},
        '{'{FUNC_SAMPLE,      36'h8_0000_0002, 6'd0,  8'd0},   1'b0, ZERO_RSP},
        '{'{FUNC_SAMPLE,      36'h4_0000_0000, 6'd0,  8'd0},   1'b0, ZERO_RSP},
        '{'{FUNC_MAP_WRITE,   36'h0,           6'd2,  8'd34},  1'b0, ZERO_RSP},
        '{'{FUNC_SAMPLE,      36'h0_0000_000C, 6'd0,  8'd0},   1'b0, ZERO_RSP},
        '{'{FUNC_COUNT_READ,  36'h0,           6'd0,  8'd0},   1'b0, ZERO_RSP},
        '{'{FUNC_COUNT_READ,  36'h0,           6'd0,  8'd34},  1'b0, ZERO_RSP},
        '{'{FUNC_COUNT_CLEAR, 36'h0,           6'd0,  8'd0},   1'b0, ZERO_RSP},
        '{'{FUNC_COUNT_READ,  36'h0,           6'd0,  8'd3},   1'b0, ZERO_RSP},
        '{'{FUNC_MAP_WRITE,   36'h0,           6'd0,  8'd33},  1'b0, ZERO_RSP},
        '{'{FUNC_MAP_WRITE,   36'h0,           6'd33, 8'd0},   1'b0, ZERO_RSP},
        '{'{FUNC_SAMPLE,      36'h0_0000_0001, 6'd0,  8'd0},   1'b0, ZERO_RSP},
        '{'{FUNC_SAMPLE,      36'hA_5A5A_5A5A, 6'd0,  8'd0},   1'b0, ZERO_RSP}
    };

    logic clk = 1'b0;
    logic rst_n;

    tcrc_cmd_if cmd_bus ();
    tcrc_rsp_if rsp_bus ();

    touch_channel_remap_counter_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block state used for prediction.
    logic [KEY_INDEX_W-1:0] key_of_channel [CHANNELS_DEF];
    logic [KEY_MAP_W-1:0]   key_map_now;
    logic [KEY_MAP_W-1:0]   key_map_last;
    logic [COUNT_W-1:0]     touch_tally [KEYS_DEF];

    touch_rsp_t           expected_results [$];
    logic [SENSOR_W-1:0]  last_sample;
    int unsigned          send_gap_pct;
    int unsigned          sink_stall_pct;
    int unsigned          error_count;

    // Apply one accepted command to the shadow state and return its result.
    function automatic touch_rsp_t predict_touch(input touch_cmd_t item);
        touch_rsp_t           result;
        logic [KEY_MAP_W-1:0] routed;
        result = '0;
        routed = '0;
        case (item.func)
            FUNC_SAMPLE:
            begin
                for (int ch = 0; ch < CHANNELS_DEF; ch++)
                begin
                    if (item.sensor_bits[ch] && key_of_channel[ch] < KEYS_DEF)
                        routed[key_of_channel[ch]] = 1'b1;
                end
                result.new_touches = routed & ~key_map_last;
                key_map_now  = routed;
                key_map_last = routed;
                for (int k = 0; k < KEYS_DEF; k++)
                begin
                    if (result.new_touches[k])
                        touch_tally[k] = touch_tally[k] + 1'b1;
                end
            end
            FUNC_MAP_WRITE:
            begin
                if (item.channel < CHANNELS_DEF)
                    key_of_channel[item.channel] = item.key_index;
            end
            FUNC_COUNT_READ:
            begin
                if (item.key_index < KEYS_DEF)
                    result.key_count = touch_tally[item.key_index];
            end
            default:
            begin
                for (int k = 0; k < KEYS_DEF; k++)
                    touch_tally[k] = '0;
            end
        endcase
        result.touched_keys = key_map_now;
        return result;
    endfunction

    // Random command: mostly samples that hold or shift the touch pattern, plus
    // table writes, count reads and the occasional clear.
    function automatic touch_cmd_t random_touch_cmd();
        touch_cmd_t  item;
        logic [63:0] wide;
        int unsigned pick;
        pick           = $urandom_range(99);
        wide           = {$urandom, $urandom};
        item.sensor_bits = wide[SENSOR_W-1:0];
        item.channel   = CHANNEL_W'($urandom_range(63));
        item.key_index = KEY_INDEX_W'($urandom_range(255));
        if (pick < 55)
        begin
            item.func = FUNC_SAMPLE;
            case ($urandom_range(4))
                0: item.sensor_bits = SENSOR_W'(1) << $urandom_range(SENSOR_W - 1);
                1, 2: item.sensor_bits = last_sample ^
                        (SENSOR_W'(1) << $urandom_range(SENSOR_W - 1));
                3: item.sensor_bits = $urandom_range(1) ? ALL_CHANNELS : '0;
                default: ;
            endcase
            last_sample = item.sensor_bits;
        end
        else if (pick < 75)
        begin
            item.func = FUNC_MAP_WRITE;
            if ($urandom_range(99) < 85)
                item.channel = CHANNEL_W'($urandom_range(CHANNELS_DEF - 1));
            if ($urandom_range(99) < 80)
                item.key_index = KEY_INDEX_W'($urandom_range(KEYS_DEF - 1));
        end
        else if (pick < 97)
        begin
            item.func = FUNC_COUNT_READ;
            if ($urandom_range(99) < 85)
                item.key_index = KEY_INDEX_W'($urandom_range(KEYS_DEF - 1));
        end
        else
        begin
            item.func = FUNC_COUNT_CLEAR;
        end
        return item;
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    // Offer one item after a random gap, wait for the handshake, then record
    // what the block should answer.
    task automatic issue_touch_cmd(input touch_cmd_t item, input logic has_answer,
                                   input touch_rsp_t answer);
        touch_rsp_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid       <= 1'b1;
        cmd_bus.func        <= item.func;
        cmd_bus.sensor_bits <= item.sensor_bits;
        cmd_bus.channel     <= item.channel;
        cmd_bus.key_index   <= item.key_index;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = predict_touch(item);
        expected_results.push_back(has_answer ? answer : predicted);
    endtask

    // Response side: compare each accepted result item with the oldest expectation.
    initial
    begin
        touch_rsp_t want;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result item arrived with nothing expected");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_bus.touched_keys !== want.touched_keys)
                        report_mismatch($sformatf("touched_keys %h, expected %h",
                                                  rsp_bus.touched_keys, want.touched_keys));
                    if (rsp_bus.new_touches !== want.new_touches)
                        report_mismatch($sformatf("new_touches %h, expected %h",
                                                  rsp_bus.new_touches, want.new_touches));
                    if (rsp_bus.key_count !== want.key_count)
                        report_mismatch($sformatf("key_count %h, expected %h",
                                                  rsp_bus.key_count, want.key_count));
                end
            end
            rsp_bus.ready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Stimulus: reset, directed table, then three random phases with different gap and stall rates.
    initial
    begin
        error_count    = 0;
        send_gap_pct   = 27;
        sink_stall_pct = 77;
        last_sample    = '0;
        key_map_now    = '0;
        key_map_last   = '0;
        for (int ch = 0; ch < CHANNELS_DEF; ch++)
            key_of_channel[ch] = KEY_INDEX_W'(ch);
        for (int k = 0; k < KEYS_DEF; k++)
            touch_tally[k] = '0;

        rst_n               <= 1'b0;
        cmd_bus.valid       <= 1'b0;
        cmd_bus.func        <= FUNC_SAMPLE;
        cmd_bus.sensor_bits <= '0;
        cmd_bus.channel     <= '0;
        cmd_bus.key_index   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
            issue_touch_cmd(DIRECTED[i].cmd, DIRECTED[i].has_answer, DIRECTED[i].answer);

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_gap_pct   = 77;
                sink_stall_pct = 27;
            end
            else if (phase == 2)
            begin
                send_gap_pct   = 0;
                sink_stall_pct = 0;
            end
            for (int n = 0; n < 130; n++)
                issue_touch_cmd(random_touch_cmd(), 1'b0, ZERO_RSP);
        end
        cmd_bus.valid <= 1'b0;

        // Drain, then wait for any stray result item.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/tcrc_pkg.sv
sv/tcrc_cmd_if.sv
sv/tcrc_rsp_if.sv
sv/touch_channel_remap_counter_top.sv
test/touch_channel_remap_counter_top_tb.sv
